/* src/vda_pkg.sv */
// Package for the vector distance accumulator.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vda_pkg;
  localparam int OUT_W = 44;
  localparam int ACC_W = 64;
  localparam int CAP_EXP = 61;
  localparam int Q_BITS = 16;

  typedef enum logic [1:0] {
    METRIC_L2  = 2'd0,
    METRIC_DOT = 2'd1,
    METRIC_COS = 2'd2,
    METRIC_RSV = 2'd3
  } metric_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_ACC,
    ST_COS_PREP,
    ST_COS_STEP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic cos_prep;
    logic cos_step;
    logic finish;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic cos_need;
    logic cos_done;
  } stat_t;
endpackage
`default_nettype wire

/* src/vda_ctrl.sv */
// Controller for the vector distance accumulator.
// Sequences product, accumulate, cosine search and output; uses vda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vda_ctrl import vda_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  wire   out_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_ACC;
      ST_ACC: begin
        if (!st.last) state_nxt = ST_IDLE;
        else state_nxt = ST_COS_PREP;
      end
      ST_COS_PREP: begin
        if (st.cos_need) state_nxt = ST_COS_STEP;
        else state_nxt = ST_OUT;
      end
      ST_COS_STEP: if (st.cos_done) state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PROD: cmd.acc = 1'b0;
      ST_ACC: cmd.acc = 1'b1;
      ST_COS_PREP: begin
        cmd.cos_prep = 1'b1;
        cmd.finish = ~st.cos_need;
      end
      ST_COS_STEP: begin
        cmd.cos_step = 1'b1;
        cmd.finish = st.cos_done;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.clear = out_ready;
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

/* src/vda_dp.sv */
// Datapath for the vector distance accumulator.
// Products, saturating sums, bit-serial cosine search; uses vda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vda_dp import vda_pkg::*; #(
  parameter int MAX_DIM = 1024,
  parameter int ELEM_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  signed [15:0]      in_elem_a,
  input  wire  signed [15:0]      in_elem_b,
  input  wire                     in_last_element,
  input  wire  [1:0]              metric,
  input  cmd_t                    cmd,
  output stat_t                   st,
  output logic signed [OUT_W-1:0] out_distance,
  output logic                    out_too_long,
  output logic                    out_zero_norm
);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int EW = ELEM_BITS + 1;
  localparam int PW = 2 * EW;
  localparam logic [ACC_W-1:0] CAP = ACC_W'(1) << CAP_EXP;
  localparam logic [ACC_W-1:0] OLIM = ACC_W'(1) << (OUT_W - 1);
  localparam logic [ACC_W-1:0] OMAX = OLIM - ACC_W'(1);
  localparam int QI_W = $clog2(Q_BITS);
  localparam int BW = 256;

  logic signed [EW-1:0] a_r, b_r;
  logic last_r;
  logic neg_r;
  logic [PW-1:0] pdd_r, pab_r, paa_r, pbb_r;
  logic [ACC_W-1:0] sq_r, na_r, nb_r;
  logic signed [ACC_W-1:0] dot_r;
  logic [CNT_W-1:0] cnt_r;
  logic ovf_r;

  function automatic logic signed [EW-1:0] sx(input logic [15:0] x);
    logic [ELEM_BITS-1:0] t;
    t = ELEM_BITS'({{(ELEM_BITS > 16 ? ELEM_BITS - 16 : 0){x[15]}}, x});
    return EW'(signed'(t));
  endfunction

  function automatic logic [EW-1:0] absv(input logic signed [EW-1:0] v);
    return v[EW-1] ? EW'(-v) : EW'(v);
  endfunction

  function automatic logic [ACC_W-1:0] cap_u(input logic [ACC_W:0] v);
    return (v > {1'b0, CAP}) ? CAP : v[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] pcap(input logic [PW-1:0] p);
    logic [ACC_W+PW-1:0] w;
    w = (ACC_W + PW)'(p);
    return (w > (ACC_W + PW)'(CAP)) ? CAP : w[ACC_W-1:0];
  endfunction

  function automatic logic [2*Q_BITS+1:0] qsq(input logic [Q_BITS:0] v);
    return v * v;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= sx(in_elem_a);
      b_r <= sx(in_elem_b);
      last_r <= in_last_element;
    end
  end

  logic signed [EW:0] diff;
  assign diff = (EW + 1)'(a_r) - (EW + 1)'(b_r);

  always_ff @(posedge clk) begin
    logic [EW:0] dmw;
    dmw = diff[EW] ? (EW + 1)'(-diff) : diff;
    pdd_r <= PW'(dmw * dmw);
    pab_r <= PW'(absv(a_r) * absv(b_r));
    paa_r <= PW'(absv(a_r) * absv(a_r));
    pbb_r <= PW'(absv(b_r) * absv(b_r));
    neg_r <= a_r[EW-1] ^ b_r[EW-1];
  end

  logic take;
  assign take = cmd.acc && (cnt_r < CNT_W'(MAX_DIM));

  logic signed [ACC_W+1:0] dsum;
  always_comb begin
    logic signed [ACC_W+1:0] pr;
    pr = signed'((ACC_W + 2)'(pcap(pab_r)));
    if (neg_r) pr = -pr;
    dsum = (ACC_W + 2)'(dot_r) + pr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sq_r <= '0; na_r <= '0; nb_r <= '0; dot_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
    end else if (cmd.acc) begin
      if (take) begin
        cnt_r <= cnt_r + CNT_W'(1);
        sq_r <= cap_u((ACC_W + 1)'(sq_r) + (ACC_W + 1)'(pcap(pdd_r)));
        na_r <= cap_u((ACC_W + 1)'(na_r) + (ACC_W + 1)'(pcap(paa_r)));
        nb_r <= cap_u((ACC_W + 1)'(nb_r) + (ACC_W + 1)'(pcap(pbb_r)));
        if (dsum > signed'((ACC_W + 2)'(CAP))) dot_r <= signed'(CAP);
        else if (dsum < -signed'((ACC_W + 2)'(CAP))) dot_r <= -signed'(CAP);
        else dot_r <= dsum[ACC_W-1:0];
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // cosine: bitwise search of q with q^2*na*nb <= dot^2*2^30
  // products built as sequential shift-add over 64 bit multiplier words
  logic [BW-1:0] lhs_r, rhs_r, acc_r, mcand_r;
  logic [ACC_W-1:0] mplier_r;
  logic [1:0] phase_r;
  logic [QI_W:0] bit_r;
  logic [Q_BITS:0] q_r, qt;
  logic [6:0] sh_r;
  logic done_r;
  logic [ACC_W-1:0] dmag;
  assign dmag = dot_r[ACC_W-1] ? ACC_W'(-dot_r) : ACC_W'(dot_r);
  assign qt = q_r | ((Q_BITS + 1)'(1) << bit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      phase_r <= '0;
    end else if (cmd.cos_prep) begin
      done_r <= 1'b0;
      phase_r <= 2'd0;
      q_r <= '0;
      bit_r <= (QI_W + 1)'(Q_BITS - 1);
      acc_r <= '0;
      mcand_r <= BW'(na_r);
      mplier_r <= nb_r;
      sh_r <= 7'd0;
    end else if (cmd.cos_step && !done_r) begin
      if (sh_r != 7'd64) begin
        if (mplier_r[0]) acc_r <= acc_r + mcand_r;
        mcand_r <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        sh_r <= sh_r + 7'd1;
      end else begin
        sh_r <= 7'd0;
        acc_r <= '0;
        case (phase_r)
          2'd0: begin
            lhs_r <= acc_r;
            mcand_r <= BW'(dmag);
            mplier_r <= dmag;
            phase_r <= 2'd1;
          end
          2'd1: begin
            rhs_r <= acc_r << 30;
            mcand_r <= lhs_r;
            mplier_r <= ACC_W'(qsq(qt));
            phase_r <= 2'd2;
          end
          2'd2: begin
            if (acc_r <= rhs_r) q_r <= qt;
            mcand_r <= lhs_r;
            if (bit_r == '0) begin
              done_r <= 1'b1;
              mplier_r <= '0;
            end else begin
              bit_r <= bit_r - (QI_W + 1)'(1);
              mplier_r <= ACC_W'(qsq(q_r | ((acc_r <= rhs_r) ? qt : '0)
                          | ((Q_BITS + 1)'(1) << (bit_r - (QI_W + 1)'(1)))));
            end
          end
          default: phase_r <= 2'd0;
        endcase
      end
    end
  end

  always_comb begin
    st.last = last_r;
    st.cos_need = (metric == METRIC_COS) && na_r != '0 && nb_r != '0;
    st.cos_done = done_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_too_long <= ovf_r | (cmd.acc & ~take);
      out_zero_norm <= 1'b0;
      case (metric_t'(metric))
        METRIC_L2: out_distance <= (sq_r > OMAX)
          ? {1'b0, {(OUT_W - 1){1'b1}}} : sq_r[OUT_W-1:0];
        METRIC_DOT: begin
          if (dot_r > signed'(OMAX))
            out_distance <= {1'b0, {(OUT_W - 1){1'b1}}};
          else if (dot_r < -signed'(OLIM))
            out_distance <= {1'b1, {(OUT_W - 1){1'b0}}};
          else out_distance <= dot_r[OUT_W-1:0];
        end
        METRIC_COS: begin
          if (!st.cos_need) begin
            out_distance <= '0;
            out_zero_norm <= 1'b1;
          end else if (dot_r[ACC_W-1])
            out_distance <= -OUT_W'(q_r);
          else
            out_distance <= q_r[Q_BITS-1] ? OUT_W'(32767) : OUT_W'(q_r);
        end
        default: out_distance <= '0;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/vector_distance_accumulator.sv */
// Top level of the vector distance accumulator.
// Joins vda_ctrl and vda_dp; holds the metric register; uses vda_pkg.
//
// Input channel in_*: one element pair per transfer with a last flag.
// An element is registered, multiplied and accumulated before the
// next transfer is taken. On the last element one result goes out on out_*.
// L2 and dot results are registered in the cosine-prepare state that follows the
// accumulate state; cosine runs a 16-bit restoring search whose products use a
// shift-add multiplier. The result is held until taken;
// while it waits no new element is taken. Accumulators clear on the
// result transfer. Reset clears accumulators, metric and control.
// cfg_we/cfg_wdata write the metric register (0 L2, 1 dot, 2 cosine).
`timescale 1ns / 1ps
`default_nettype none
module vector_distance_accumulator import vda_pkg::*; #(
  parameter int MAX_DIM = 1024,
  parameter int ELEM_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  signed [15:0]      in_elem_a,
  input  wire  signed [15:0]      in_elem_b,
  input  wire                     in_last_element,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [OUT_W-1:0] out_distance,
  output logic                    out_too_long,
  output logic                    out_zero_norm,
  input  wire                     cfg_we,
  input  wire  [1:0]              cfg_wdata
);
  logic [1:0] metric_r;
  cmd_t cmd;
  stat_t st;

  always_ff @(posedge clk) begin
    if (!rst_n) metric_r <= METRIC_L2;
    else if (cfg_we) metric_r <= cfg_wdata;
  end

  vda_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
  );

  vda_dp #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
    .clk, .rst_n, .in_elem_a, .in_elem_b, .in_last_element,
    .metric(metric_r), .cmd, .st, .out_distance, .out_too_long, .out_zero_norm
  );
endmodule
`default_nettype wire

/* sim/vector_distance_accumulator_tb.sv */
// Testbench for vector_distance_accumulator: directed table, then random vectors,
// checked against a behavioral predictor of the L2 / dot / cosine accumulator.
// Depends on vda_pkg and the RTL top level only.
`timescale 1ns / 1ps
module vector_distance_accumulator_tb;
  import vda_pkg::*;

  localparam int VEC_MAX = 1024;
  localparam int LIMIT = 3000000;

  typedef struct {
    logic signed [OUT_W-1:0] dval;
    logic                    too_long;
    logic                    zero_norm;
  } vres_t;

  typedef struct {
    metric_t              m;
    logic signed [15:0]   a;
    logic signed [15:0]   b;
    logic                 last;
    bit                   typed;
    longint               dval;
    bit                   tl;
    bit                   zn;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic signed [15:0] in_elem_a = '0;
  logic signed [15:0] in_elem_b = '0;
  logic in_last_element = 0;
  logic out_ready = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_wdata = '0;
  wire in_ready;
  wire out_valid;
  wire signed [OUT_W-1:0] out_distance;
  wire out_too_long;
  wire out_zero_norm;

  vector_distance_accumulator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_elem_a(in_elem_a), .in_elem_b(in_elem_b), .in_last_element(in_last_element),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_distance(out_distance), .out_too_long(out_too_long), .out_zero_norm(out_zero_norm),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor state
  metric_t metric_sel;
  longint unsigned sq_sum, na_sum, nb_sum;
  longint dot_acc;
  int elem_cnt;
  bit ovf;
  vres_t result_q[$];

  int in_idle_pct, out_idle_pct;
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  logic hold_kick = 0;

  function automatic int cosine_q15(longint dot, longint unsigned na, longint unsigned nb);
    logic [127:0] p, d, trial;
    longint unsigned dm, lo, hi, mid;
    dm = dot < 0 ? -dot : dot;
    p = 128'(na) * 128'(nb);
    d = (128'(dm) * 128'(dm)) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      trial = p * 128'(mid * mid);
      if (trial <= d) lo = mid;
      else hi = mid - 1;
    end
    if (dot < 0) return -int'(lo);
    return lo > 32767 ? 32767 : int'(lo);
  endfunction

  task automatic similarity_step(logic signed [15:0] a, logic signed [15:0] b, logic last);
    longint sa, sb, dm;
    longint dval;
    vres_t r;
    sa = a;
    sb = b;
    if (elem_cnt >= VEC_MAX) begin
      ovf = 1;
    end else begin
      elem_cnt++;
      dm = sa - sb;
      sq_sum += dm * dm;
      dot_acc += sa * sb;
      na_sum += sa * sa;
      nb_sum += sb * sb;
    end
    if (!last) return;
    dval = 0;
    r.zero_norm = 0;
    case (metric_sel)
      METRIC_L2: dval = longint'(sq_sum);
      METRIC_DOT: dval = dot_acc;
      METRIC_COS: begin
        if (na_sum == 0 || nb_sum == 0) r.zero_norm = 1;
        else dval = cosine_q15(dot_acc, na_sum, nb_sum);
      end
      default: dval = 0;
    endcase
    if (dval > 64'sd8796093022207) dval = 64'sd8796093022207;
    if (dval < -64'sd8796093022208) dval = -64'sd8796093022208;
    r.dval = dval[OUT_W-1:0];
    r.too_long = ovf;
    result_q.push_back(r);
    sq_sum = 0;
    dot_acc = 0;
    na_sum = 0;
    nb_sum = 0;
    elem_cnt = 0;
    ovf = 0;
  endtask

  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_elem_a <= a;
    in_elem_b <= b;
    in_last_element <= last;
    do @(posedge clk); while (!in_ready);
    similarity_step(a, b, last);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_metric(metric_t m);
    cfg_we <= 1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 0;
    metric_sel = m;
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'($urandom_range(15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_vectors(int items);
    int sent, len;
    metric_t m;
    sent = 0;
    while (sent < items) begin
      wait_idle();
      m = metric_t'($urandom_range(3));
      set_metric(m);
      for (int v = 0; v < 12 && sent < items; v++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        for (int k = 0; k < len; k++) send_pair(pick_elem(), pick_elem(), k == len - 1);
        sent += len;
      end
    end
  endtask

  // receiver; hold-off counted separately
  always @(posedge clk) begin
    if (hold_kick) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    vres_t e;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: dist=%0d", out_distance);
      end else begin
        e = result_q.pop_front();
        if (out_distance !== e.dval || out_too_long !== e.too_long
            || out_zero_norm !== e.zero_norm) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp dist=%0d tl=%b zn=%b, got dist=%0d tl=%b zn=%b",
                     e.dval, e.too_long, e.zero_norm,
                     out_distance, out_too_long, out_zero_norm);
        end
      end
    end
    if (hold_kick || hold_left > 1) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** vector_distance_accumulator: FAILED **");
      $finish;
    end
  end

  row_t dir_tab[] = '{
    '{METRIC_L2, 16'sd32767, -16'sd32768, 1, 1, 64'd4294836225, 0, 0},
    '{METRIC_L2, -16'sd32768, 16'sd32767, 1, 1, 64'd4294836225, 0, 0},
    '{METRIC_L2, 16'sd0, 16'sd0, 1, 1, 0, 0, 0},
    '{METRIC_L2, 16'sd100, -16'sd100, 0, 0, 0, 0, 0},
    '{METRIC_L2, -16'sd1, 16'sd1, 0, 0, 0, 0, 0},
    '{METRIC_L2, 16'sd5, 16'sd5, 1, 0, 0, 0, 0},
    '{METRIC_DOT, -16'sd32768, -16'sd32768, 1, 1, 64'd1073741824, 0, 0},
    '{METRIC_DOT, -16'sd32768, 16'sd32767, 1, 1, -64'sd1073709056, 0, 0},
    '{METRIC_DOT, 16'sd32767, 16'sd32767, 0, 0, 0, 0, 0},
    '{METRIC_DOT, -16'sd3, 16'sd7, 1, 0, 0, 0, 0},
    '{METRIC_COS, 16'sd0, 16'sd5, 1, 1, 0, 0, 1},
    '{METRIC_COS, 16'sd5, 16'sd0, 1, 1, 0, 0, 1},
    '{METRIC_COS, 16'sd1000, 16'sd1000, 1, 1, 32767, 0, 0},
    '{METRIC_COS, 16'sd1000, -16'sd1000, 1, 1, -32768, 0, 0},
    '{METRIC_COS, 16'sd300, -16'sd20, 0, 0, 0, 0, 0},
    '{METRIC_COS, 16'sd7, 16'sd9, 1, 0, 0, 0, 0},
    '{METRIC_COS, 16'sd0, 16'sd0, 0, 0, 0, 0, 0},
    '{METRIC_COS, 16'sd0, 16'sd0, 1, 1, 0, 0, 1},
    '{METRIC_RSV, 16'sd123, 16'sd456, 1, 1, 0, 0, 0}
  };

  initial begin
    vres_t r;
    metric_sel = METRIC_L2;
    sq_sum = 0;
    dot_acc = 0;
    na_sum = 0;
    nb_sum = 0;
    elem_cnt = 0;
    ovf = 0;
    in_idle_pct = 21;
    out_idle_pct = 57;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].m != metric_sel) begin
        wait_idle();
        set_metric(dir_tab[i].m);
      end
      send_pair(dir_tab[i].a, dir_tab[i].b, dir_tab[i].last);
      if (dir_tab[i].typed) begin
        r = result_q.pop_back();
        r.dval = dir_tab[i].dval[OUT_W-1:0];
        r.too_long = dir_tab[i].tl;
        r.zero_norm = dir_tab[i].zn;
        result_q.push_back(r);
      end
    end

    // vector longer than the element limit
    wait_idle();
    set_metric(METRIC_L2);
    for (int k = 0; k < VEC_MAX + 6; k++) send_pair(pick_elem(), pick_elem(), k == VEC_MAX + 5);

    random_vectors(20);
    in_idle_pct = 57;
    out_idle_pct = 21;
    random_vectors(20);
    in_idle_pct = 0;
    out_idle_pct = 0;
    wait_idle();
    hold_kick <= 1;
    @(posedge clk);
    hold_kick <= 0;
    random_vectors(20);

    wait_idle();
    if (errors == 0) begin
      $display("** vector_distance_accumulator: PASSED **");
    end else begin
      $display("** vector_distance_accumulator: FAILED **");
    end
    $finish;
  end
endmodule
